>>> rtl/pcf_pkg.sv
// Shared constants and beat types for the pairwise Coulomb force block.
package pcf_pkg;

	localparam int MAX_ATOMS  = 32;
	localparam int AW         = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
	localparam int CW         = $clog2(MAX_ATOMS + 1);
	localparam int FIFO_DEPTH = 2;
	localparam int FPW        = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FCW        = $clog2(FIFO_DEPTH + 1);

	localparam logic signed [47:0] FMAX = 48'sh7FFF_FFFF_FFFF;

	typedef logic [AW-1:0] aidx_t;
	typedef logic [CW-1:0] acnt_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [15:0]        q;
	} atom_t;

	// one beat from front to back: a pair, or the end-of-set marker
	typedef struct packed {
		logic  flush;
		aidx_t a1;
		aidx_t a2;
		acnt_t n;
		atom_t p1;
		atom_t p2;
	} pair_t;

	typedef struct packed {
		logic signed [47:0] x;
		logic signed [47:0] y;
		logic signed [47:0] z;
		logic               sat;
	} acc_t;

endpackage

>>> rtl/pcf_front.sv
// Front end: atom loading, atom store and pair sequencing.
module pcf_front import pcf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [15:0]        charge,
	input  logic               last_atom,
	output logic               push,
	output pair_t              push_data,
	input  logic               full
);

	typedef enum logic [2:0] {F_LOAD, F_RA, F_RB, F_PUSH, F_FLUSH} fstate_t;

	fstate_t state_q;
	acnt_t   count_q;
	acnt_t   n_q;
	aidx_t   a1_q;
	aidx_t   a2_q;
	atom_t   p1_q;
	atom_t   rd_q;
	atom_t   mem [MAX_ATOMS];

	logic  accept;
	logic  wr;
	logic  rd_en;
	aidx_t rd_addr;
	acnt_t count_nx;

	assign busy     = (state_q != F_LOAD);
	assign accept   = start && (state_q == F_LOAD);
	assign wr       = accept && (count_q < CW'(MAX_ATOMS));
	assign count_nx = wr ? count_q + CW'(1) : count_q;
	assign rd_en    = (state_q == F_RA) || (state_q == F_RB);
	assign rd_addr  = (state_q == F_RA) ? a1_q : a2_q;

	// pair beat towards the queue
	assign push = ((state_q == F_PUSH) || (state_q == F_FLUSH)) && !full;
	always_comb begin
		push_data.flush = (state_q == F_FLUSH);
		push_data.a1    = a1_q;
		push_data.a2    = a2_q;
		push_data.n     = n_q;
		push_data.p1    = p1_q;
		push_data.p2    = rd_q;
	end

	// atom store, registered read
	always_ff @(posedge clk) begin
		if (wr) begin
			mem[count_q[AW-1:0]] <= '{x: pos_x, y: pos_y, z: pos_z, q: charge};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// loader and pair sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_LOAD;
			count_q <= '0;
			n_q     <= '0;
			a1_q    <= '0;
			a2_q    <= '0;
		end else begin
			unique case (state_q)
				F_LOAD: begin
					if (accept) begin
						if (last_atom) begin
							n_q     <= count_nx;
							count_q <= '0;
							a1_q    <= AW'(1);
							a2_q    <= '0;
							state_q <= (count_nx >= CW'(2)) ? F_RA : F_FLUSH;
						end else begin
							count_q <= count_nx;
						end
					end
				end
				F_RA: state_q <= F_RB;
				F_RB: state_q <= F_PUSH;
				F_PUSH: begin
					if (!full) begin
						if (CW'(a2_q) + CW'(1) < CW'(a1_q)) begin
							a2_q    <= a2_q + AW'(1);
							state_q <= F_RA;
						end else if (CW'(a1_q) + CW'(1) < n_q) begin
							a1_q    <= a1_q + AW'(1);
							a2_q    <= '0;
							state_q <= F_RA;
						end else begin
							state_q <= F_FLUSH;
						end
					end
				end
				F_FLUSH: begin
					if (!full) begin
						state_q <= F_LOAD;
					end
				end
				default: state_q <= F_LOAD;
			endcase
		end
	end

	// p1 is the first of the two reads of a pair
	always_ff @(posedge clk) begin
		if (state_q == F_RB) begin
			p1_q <= rd_q;
		end
	end

endmodule

>>> rtl/pcf_fifo.sv
// Short queue of pair beats between front and back.
module pcf_fifo import pcf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  pair_t push_data,
	output logic  full,
	input  logic  pop,
	output pair_t pop_data,
	output logic  empty
);

	pair_t            buf_q [FIFO_DEPTH];
	logic [FPW-1:0]   wp_q;
	logic [FPW-1:0]   rp_q;
	logic [FCW-1:0]   cnt_q;

	assign full     = (cnt_q == FCW'(FIFO_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= push_data;
		end
	end

	// pointers wrap at the queue depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (FCW'(wp_q) == FCW'(FIFO_DEPTH - 1)) ? '0 : wp_q + FPW'(1);
			end
			if (pop) begin
				rp_q <= (FCW'(rp_q) == FCW'(FIFO_DEPTH - 1)) ? '0 : rp_q + FPW'(1);
			end
			cnt_q <= cnt_q + FCW'(push) - FCW'(pop);
		end
	end

	a_no_overrun:  assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("pair queue written while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("pair queue read while empty");

endmodule

>>> rtl/pcf_back.sv
// Back end: pair force engine, force accumulators and result emission.
module pcf_back import pcf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  pair_t              pop_data,
	output logic               pop,
	output logic               strobe,
	output logic [4:0]         atom_index,
	output logic signed [47:0] force_x,
	output logic signed [47:0] force_y,
	output logic signed [47:0] force_z,
	output logic               saturated,
	output logic               last_force
);

	typedef enum logic [3:0] {
		B_IDLE, B_DIFF, B_SQ, B_PROD, B_SQRT, B_R3A, B_R3B, B_R3C,
		B_DIV, B_RD1, B_WR1, B_RD2, B_WR2, B_EMIT
	} bstate_t;

	bstate_t            state_q;
	pair_t              pr_q;
	logic [2:0]         neg_q;
	logic [2:0]         nz_q;
	logic [31:0]        mag_q [3];
	logic [63:0]        p_q [3];
	logic [47:0]        fm_q [3];
	logic [31:0]        qq_q;
	logic [63:0]        r2_q;
	logic [63:0]        v_q;
	logic [63:0]        res_q;
	logic [63:0]        bit_q;
	logic [63:0]        ppl_q;
	logic [63:0]        pph_q;
	logic [95:0]        r3_q;
	logic [95:0]        rem_q;
	logic [46:0]        quo_q;
	logic               qovf_q;
	logic               ovf_q;
	logic [1:0]         c_q;
	logic [6:0]         step_q;
	aidx_t              e_q;
	aidx_t              idx_q;
	logic               strobe_q;
	logic               last_q;
	logic [MAX_ATOMS-1:0] vld_q;
	logic               rdv_q;
	acc_t               acc_rd_q;
	acc_t               acc_mem [MAX_ATOMS];

	logic signed [32:0] dif [3];
	logic [31:0]        mag_c;
	logic [63:0]        p_c;
	logic [63:0]        sq;
	logic [63:0]        trial;
	logic [6:0]         pb;
	logic               nbit;
	logic [96:0]        sh;
	logic               ge;
	logic [46:0]        qfin;
	logic signed [47:0] fs [3];
	logic signed [47:0] addend [3];
	acc_t               old;
	acc_t               acc_wd;
	logic [2:0]         addsat;
	logic               acc_we;
	aidx_t              acc_a;
	logic               last_e;

	// saturating accumulate: {flag, value}
	function automatic logic [48:0] sat_add(input logic signed [47:0] a,
	                                        input logic signed [47:0] b);
		logic signed [48:0] s;
		s = 49'(a) + 49'(b);
		if (s > 49'(FMAX)) begin
			sat_add = {1'b1, FMAX};
		end else if (s < -49'(FMAX)) begin
			sat_add = {1'b1, -FMAX};
		end else begin
			sat_add = {1'b0, s[47:0]};
		end
	endfunction

	// component differences
	always_comb begin
		dif[0] = {pr_q.p1.x[31], pr_q.p1.x} - {pr_q.p2.x[31], pr_q.p2.x};
		dif[1] = {pr_q.p1.y[31], pr_q.p1.y} - {pr_q.p2.y[31], pr_q.p2.y};
		dif[2] = {pr_q.p1.z[31], pr_q.p1.z} - {pr_q.p2.z[31], pr_q.p2.z};
	end

	assign mag_c = mag_q[c_q];
	assign p_c   = p_q[c_q];
	assign sq    = mag_c * mag_c;
	assign trial = res_q + bit_q;

	// divider step: numerator is p * 2^45, one bit a cycle
	assign pb   = step_q - 7'd45;
	assign nbit = (step_q >= 7'd45 && step_q <= 7'd108) ? p_c[pb[5:0]] : 1'b0;
	assign sh   = {rem_q, nbit};
	assign ge   = sh >= {1'b0, r3_q};
	assign qfin = {quo_q[45:0], ge};

	// signed pair force on atom a1; a2 gets the negation
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			fs[c]     = (nz_q[c] && !neg_q[c]) ? -$signed(fm_q[c]) : $signed(fm_q[c]);
			addend[c] = (state_q == B_WR2) ? -fs[c] : fs[c];
		end
	end

	// accumulator update; entries not written in this set read as zero
	always_comb begin
		logic [48:0] rx, ry, rz;
		old       = rdv_q ? acc_rd_q : '0;
		rx        = sat_add(old.x, addend[0]);
		ry        = sat_add(old.y, addend[1]);
		rz        = sat_add(old.z, addend[2]);
		addsat    = {rz[48], ry[48], rx[48]};
		acc_wd.x  = rx[47:0];
		acc_wd.y  = ry[47:0];
		acc_wd.z  = rz[47:0];
		acc_wd.sat = old.sat | ovf_q | (|addsat);
	end

	assign acc_we = (state_q == B_WR1) || (state_q == B_WR2);
	assign acc_a  = (state_q == B_RD1 || state_q == B_WR1) ? pr_q.a1 :
	                (state_q == B_RD2 || state_q == B_WR2) ? pr_q.a2 : e_q;
	assign last_e = (CW'(e_q) + CW'(1) == pr_q.n);
	assign pop    = (state_q == B_IDLE) && !empty;

	// accumulator memory, registered read
	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_mem[acc_a] <= acc_wd;
		end
		acc_rd_q <= acc_mem[acc_a];
	end

	// result ports
	assign strobe     = strobe_q;
	assign atom_index = 5'(idx_q);
	assign force_x    = rdv_q ? acc_rd_q.x : '0;
	assign force_y    = rdv_q ? acc_rd_q.y : '0;
	assign force_z    = rdv_q ? acc_rd_q.z : '0;
	assign saturated  = rdv_q ? acc_rd_q.sat : 1'b0;
	assign last_force = last_q;

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			vld_q    <= '0;
			rdv_q    <= 1'b0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			idx_q    <= '0;
			e_q      <= '0;
			c_q      <= '0;
			step_q   <= '0;
		end else begin
			strobe_q <= 1'b0;
			rdv_q    <= vld_q[acc_a];
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						e_q     <= '0;
						state_q <= pop_data.flush ? B_EMIT : B_DIFF;
					end
				end
				B_DIFF: begin
					c_q     <= '0;
					state_q <= B_SQ;
				end
				B_SQ: begin
					c_q     <= (c_q == 2'd2) ? 2'd0 : c_q + 2'd1;
					state_q <= (c_q == 2'd2) ? B_PROD : B_SQ;
				end
				B_PROD: begin
					if (c_q == 2'd2) begin
						c_q     <= '0;
						state_q <= (r2_q == '0) ? B_RD1 : B_SQRT;
					end else begin
						c_q <= c_q + 2'd1;
					end
				end
				B_SQRT: state_q <= bit_q[0] ? B_R3A : B_SQRT;
				B_R3A:  state_q <= B_R3B;
				B_R3B:  state_q <= B_R3C;
				B_R3C: begin
					c_q     <= '0;
					step_q  <= 7'd127;
					state_q <= B_DIV;
				end
				B_DIV: begin
					step_q <= step_q - 7'd1;
					if (step_q == '0) begin
						c_q     <= c_q + 2'd1;
						state_q <= (c_q == 2'd2) ? B_RD1 : B_DIV;
					end
				end
				B_RD1: state_q <= B_WR1;
				B_WR1: begin
					vld_q[acc_a] <= 1'b1;
					state_q      <= B_RD2;
				end
				B_RD2: state_q <= B_WR2;
				B_WR2: begin
					vld_q[acc_a] <= 1'b1;
					state_q      <= B_IDLE;
				end
				B_EMIT: begin
					strobe_q <= 1'b1;
					idx_q    <= e_q;
					last_q   <= last_e;
					if (last_e) begin
						vld_q   <= '0;
						state_q <= B_IDLE;
					end else begin
						e_q <= e_q + AW'(1);
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (pop) begin
					pr_q <= pop_data;
				end
				ovf_q <= 1'b0;
			end
			B_DIFF: begin
				for (int c = 0; c < 3; c++) begin
					neg_q[c] <= dif[c][32];
					nz_q[c]  <= (dif[c] != '0);
					mag_q[c] <= dif[c][32] ? 32'(-dif[c]) : dif[c][31:0];
				end
				qq_q <= {16'b0, pr_q.p1.q} * {16'b0, pr_q.p2.q};
				r2_q <= '0;
			end
			B_SQ: r2_q <= r2_q + (sq >> 2);
			B_PROD: begin
				p_q[c_q] <= mag_c * qq_q;
				v_q      <= r2_q;
				res_q    <= '0;
				bit_q    <= 64'd1 << 62;
				if (c_q == 2'd2 && r2_q == '0) begin
					// coincident atoms: full-scale force against each nonzero offset
					for (int c = 0; c < 3; c++) begin
						fm_q[c] <= nz_q[c] ? FMAX : '0;
					end
					ovf_q <= 1'b1;
				end
			end
			B_SQRT: begin
				if (v_q >= trial) begin
					v_q   <= v_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			B_R3A: ppl_q <= r2_q[31:0] * res_q[31:0];
			B_R3B: pph_q <= r2_q[63:32] * res_q[31:0];
			B_R3C: begin
				r3_q   <= {pph_q, 32'b0} + 96'(ppl_q);
				rem_q  <= '0;
				quo_q  <= '0;
				qovf_q <= 1'b0;
			end
			B_DIV: begin
				if (step_q == '0) begin
					fm_q[c_q] <= qovf_q ? FMAX : {1'b0, qfin};
					ovf_q     <= ovf_q | qovf_q;
					rem_q     <= '0;
					quo_q     <= '0;
					qovf_q    <= 1'b0;
				end else begin
					rem_q <= ge ? 96'(sh - {1'b0, r3_q}) : sh[95:0];
					quo_q <= qfin;
					if (ge && step_q >= 7'd47) begin
						qovf_q <= 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && last_q |=> !strobe_q)
		else $error("result strobe continues past the last force");
	a_idx_steps: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !last_q |=> strobe_q && idx_q == $past(idx_q) + AW'(1))
		else $error("forces not emitted in index order");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DIV |-> r3_q != '0)
		else $error("divider started with zero divisor");

endmodule

>>> rtl/pairwise_coulomb_force.sv
// Top level of the pairwise Coulomb force block.
//
// channel  | handshake          | beat
// ---------+--------------------+--------------------------------------------------
// atom in  | start & !busy      | pos_x, pos_y, pos_z, charge, last_atom
// force out| strobe (no stall)  | atom_index, force_x/y/z, saturated, last_force
//
// The last atom hands N(N-1)/2 pairs to the back end; busy stays high while the
// front reads each pair (F_RA, F_RB) and pushes it (F_PUSH), then pushes the
// end-of-set beat (F_FLUSH), waiting whenever the pair queue is full; with a
// two-beat queue the front soon waits on the back for most of the set. Each pair
// goes through the bit-serial 128-step divider, run once per component, and the
// 32-step square root; coincident atoms skip both. Forces then leave one per cycle
// after the end-of-set beat is taken. Reset clears all control state; no clearing
// pass. The next set loads while the back end still works on the previous one.
module pairwise_coulomb_force import pcf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [15:0]        charge,
	input  logic               last_atom,
	output logic               strobe,
	output logic [4:0]         atom_index,
	output logic signed [47:0] force_x,
	output logic signed [47:0] force_y,
	output logic signed [47:0] force_z,
	output logic               saturated,
	output logic               last_force
);

	logic  push;
	logic  full;
	logic  pop;
	logic  empty;
	pair_t push_data;
	pair_t pop_data;

	pcf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.charge    (charge),
		.last_atom (last_atom),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	pcf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	pcf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (empty),
		.pop_data   (pop_data),
		.pop        (pop),
		.strobe     (strobe),
		.atom_index (atom_index),
		.force_x    (force_x),
		.force_y    (force_y),
		.force_z    (force_z),
		.saturated  (saturated),
		.last_force (last_force)
	);

endmodule

>>> verif/tb_pairwise_coulomb_force.sv
// Self-checking testbench for pairwise_coulomb_force: directed and random atom sets.
`timescale 1ns / 1ps

module tb_pairwise_coulomb_force;
	import pcf_pkg::*;

	localparam longint FLIM = 64'h0000_7FFF_FFFF_FFFF;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] pos_x, pos_y, pos_z;
	logic [15:0]        charge;
	logic               last_atom;
	logic               strobe;
	logic [4:0]         atom_index;
	logic signed [47:0] force_x, force_y, force_z;
	logic               saturated;
	logic               last_force;

	typedef struct {
		logic [4:0]  idx;
		logic [47:0] fx, fy, fz;
		logic        sat;
		logic        last;
	} force_beat_t;

	force_beat_t expected_forces[$];

	// predictor copy of the stored set
	logic signed [31:0] set_x[MAX_ATOMS], set_y[MAX_ATOMS], set_z[MAX_ATOMS];
	logic [15:0]        set_q[MAX_ATOMS];
	int unsigned        set_n;
	longint             acc_x[MAX_ATOMS], acc_y[MAX_ATOMS], acc_z[MAX_ATOMS];
	bit                 acc_sat[MAX_ATOMS];

	int  errors;
	int  burst_left;
	bit  no_gaps;

	pairwise_coulomb_force dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .charge(charge),
		.last_atom(last_atom), .strobe(strobe), .atom_index(atom_index),
		.force_x(force_x), .force_y(force_y), .force_z(force_z),
		.saturated(saturated), .last_force(last_force)
	);

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] res, t;
		res = 0;
		for (int i = 31; i >= 0; i--) begin
			t = res | (64'd1 << i);
			if (t * t <= v)
				res = t;
		end
		return res;
	endfunction

	function automatic longint clamp_add(longint a, longint b, ref bit flag);
		longint s;
		s = a + b;
		if (s > FLIM) begin
			flag = 1'b1;
			return FLIM;
		end
		if (s < -FLIM) begin
			flag = 1'b1;
			return -FLIM;
		end
		return s;
	endfunction

	// force between atoms a1 and a2, added to a1 and taken from a2
	task automatic add_pair_force(int a1, int a2);
		longint       d[3];
		logic [63:0]  mag[3];
		logic [63:0]  r2, r, qq, p;
		logic [127:0] r3, num, quo;
		longint       f[3];
		bit           ovf;
		d[0] = longint'(set_x[a1]) - longint'(set_x[a2]);
		d[1] = longint'(set_y[a1]) - longint'(set_y[a2]);
		d[2] = longint'(set_z[a1]) - longint'(set_z[a2]);
		r2 = 0;
		ovf = 0;
		for (int c = 0; c < 3; c++) begin
			mag[c] = d[c] < 0 ? 64'(-d[c]) : 64'(d[c]);
			r2 += (mag[c] * mag[c]) >> 2;
		end
		qq = 64'(set_q[a1]) * 64'(set_q[a2]);
		if (r2 == 0) begin
			// coincident atoms: full-scale push, sign from d
			for (int c = 0; c < 3; c++)
				f[c] = d[c] > 0 ? -FLIM : (d[c] < 0 ? FLIM : 0);
			ovf = 1;
		end else begin
			r  = int_sqrt(r2);
			r3 = 128'(r2) * 128'(r);
			for (int c = 0; c < 3; c++) begin
				p   = mag[c] * qq;
				num = 128'(p) << 45;
				quo = num / r3;
				if (quo > 128'(FLIM)) begin
					quo = 128'(FLIM);
					ovf = 1;
				end
				f[c] = d[c] > 0 ? -longint'(quo[63:0]) : longint'(quo[63:0]);
			end
		end
		if (ovf) begin
			acc_sat[a1] = 1;
			acc_sat[a2] = 1;
		end
		acc_x[a1] = clamp_add(acc_x[a1], f[0], acc_sat[a1]);
		acc_y[a1] = clamp_add(acc_y[a1], f[1], acc_sat[a1]);
		acc_z[a1] = clamp_add(acc_z[a1], f[2], acc_sat[a1]);
		acc_x[a2] = clamp_add(acc_x[a2], -f[0], acc_sat[a2]);
		acc_y[a2] = clamp_add(acc_y[a2], -f[1], acc_sat[a2]);
		acc_z[a2] = clamp_add(acc_z[a2], -f[2], acc_sat[a2]);
	endtask

	// one accepted atom beat into the predictor
	task automatic predict_atom(logic signed [31:0] x, y, z, logic [15:0] q, logic lst);
		force_beat_t b;
		if (set_n < MAX_ATOMS) begin
			set_x[set_n] = x;
			set_y[set_n] = y;
			set_z[set_n] = z;
			set_q[set_n] = q;
			set_n++;
		end
		if (!lst)
			return;
		for (int i = 0; i < MAX_ATOMS; i++) begin
			acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0; acc_sat[i] = 0;
		end
		for (int a1 = 1; a1 < set_n; a1++)
			for (int a2 = 0; a2 < a1; a2++)
				add_pair_force(a1, a2);
		for (int a = 0; a < set_n; a++) begin
			b.idx  = 5'(a);
			b.fx   = acc_x[a][47:0];
			b.fy   = acc_y[a][47:0];
			b.fz   = acc_z[a][47:0];
			b.sat  = acc_sat[a];
			b.last = (a + 1 == set_n);
			expected_forces.insert(expected_forces.size(), b);
		end
		set_n = 0;
	endtask

	// send one atom beat; bursts of random length separated by random gaps unless no_gaps
	task automatic send_atom(logic signed [31:0] x, y, z, logic [15:0] q, logic lst);
		if (!no_gaps && burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
			burst_left = $urandom_range(1, 6);
		end
		if (burst_left > 0)
			burst_left--;
		start     <= 1'b1;
		pos_x     <= x;
		pos_y     <= y;
		pos_z     <= z;
		charge    <= q;
		last_atom <= lst;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_atom(x, y, z, q, lst);
	endtask

	task automatic send_random_atom(logic lst, logic signed [31:0] bx, by, bz, int spread);
		logic signed [31:0] x, y, z;
		if (spread == 0) begin
			x = $urandom; y = $urandom; z = $urandom;
		end else begin
			x = bx + $signed($urandom_range(0, 2 * spread)) - spread;
			y = by + $signed($urandom_range(0, 2 * spread)) - spread;
			z = bz + $signed($urandom_range(0, 2 * spread)) - spread;
		end
		send_atom(x, y, z, 16'($urandom), lst);
	endtask

	// result checker: the receiver never stalls, so every strobe is a beat
	always @(posedge clk) begin
		force_beat_t e;
		if (arst_n && strobe) begin
			if (expected_forces.size() == 0) begin
				$display("%0t: unexpected force beat idx=%0d", $time, atom_index);
				errors++;
			end else begin
				e = expected_forces.pop_front();
				if (atom_index !== e.idx || force_x !== e.fx || force_y !== e.fy ||
				    force_z !== e.fz || saturated !== e.sat || last_force !== e.last) begin
					$display("%0t: expected idx=%0d f=(%h,%h,%h) sat=%b last=%b", $time,
						e.idx, e.fx, e.fy, e.fz, e.sat, e.last);
					$display("%0t: actual   idx=%0d f=(%h,%h,%h) sat=%b last=%b", $time,
						atom_index, force_x, force_y, force_z, saturated, last_force);
					errors++;
				end
			end
		end
	end

	// position and charge extremes
	task automatic test_extremes();
		send_atom(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 16'hFFFF, 1'b0);
		send_atom(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF, 1'b0);
		send_atom(32'sh0, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'h0000, 1'b1);
		send_atom(32'sh0010_0000, 32'sh0, 32'sh0, 16'h0100, 1'b0);
		send_atom(32'sh0, 32'sh0010_0000, 32'sh0, 16'h0100, 1'b0);
		send_atom(32'sh0, 32'sh0, 32'sh0000_0001, 16'hFFFF, 1'b1);
	endtask

	// coincident atoms, also with zero charge, and a crowd that saturates sums
	task automatic test_coincident();
		send_atom(32'sh0123_4567, -32'sh0010_0000, 32'sh0, 16'h0000, 1'b0);
		send_atom(32'sh0123_4567, -32'sh0010_0000, 32'sh0, 16'h0000, 1'b1);
		send_atom(32'sh1, 32'sh0, -32'sh1, 16'h0800, 1'b0);
		send_atom(32'sh1, 32'sh0, -32'sh1, 16'h0800, 1'b0);
		send_atom(32'sh1, 32'sh0, -32'sh1, 16'h0800, 1'b0);
		send_atom(32'sh2, 32'sh1, -32'sh2, 16'h0800, 1'b0);
		send_atom(32'sh0, 32'sh1, 32'sh0, 16'h0800, 1'b1);
	endtask

	// a set of one atom gives a single zero force
	task automatic test_single_atom();
		send_atom(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh5555_5555, 16'hFFFF, 1'b1);
		send_atom(32'sh0, 32'sh0, 32'sh0, 16'h0000, 1'b1);
	endtask

	// full set plus dropped extras, the last dropped one closing the set
	task automatic test_full_set();
		for (int i = 0; i < MAX_ATOMS + 2; i++)
			send_random_atom(i == MAX_ATOMS + 1, 32'sh0, 32'sh0, 32'sh0, 32'h0400_0000);
	endtask

	// random sets: mostly clustered positions, some wild, sizes mostly small
	task automatic test_random_sets(int items);
		int sent, n, spread;
		logic signed [31:0] bx, by, bz;
		sent = 0;
		while (sent < items) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
			no_gaps = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 3))
				0:       spread = 0;
				1:       spread = 32'h0000_0400;
				2:       spread = 32'h0010_0000;
				default: spread = 32'h0400_0000;
			endcase
			bx = $urandom; by = $urandom; bz = $urandom;
			for (int i = 0; i < n; i++)
				send_random_atom(i == n - 1, bx, by, bz, spread);
			sent += n;
		end
		no_gaps = 0;
	endtask

	initial begin
		errors     = 0;
		set_n      = 0;
		burst_left = 0;
		no_gaps    = 0;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		pos_x     <= '0;
		pos_y     <= '0;
		pos_z     <= '0;
		charge    <= '0;
		last_atom <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_coincident();
		test_single_atom();
		test_full_set();
		test_random_sets(420);

		start <= 1'b0;
		while (expected_forces.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("pairwise_coulomb_force: match");
		else
			$display("pairwise_coulomb_force: mismatch");
		$finish;
	end

	// watchdog
	initial begin
		#(64'd12 * 64'd5_000_000);
		$display("pairwise_coulomb_force: mismatch");
		$finish;
	end

endmodule
